/* rtl/core/mono_framebuffer_raster_ops_assert.svh */
// Assertion macros used by the raster engine back end (mfbro_back).
// They sample on clk_i and are off while rst_ni is low.
`ifndef MONO_FRAMEBUFFER_RASTER_OPS_ASSERT_SVH
`define MONO_FRAMEBUFFER_RASTER_OPS_ASSERT_SVH

`define MFBRO_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define MFBRO_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/mfbro_pkg.sv */
package mfbro_pkg;

  localparam int DefLineCount = 128;
  localparam int DefPageCount = 4;
  localparam int PageBits     = 8;
  localparam int MaxLineBits  = 32;
  localparam int LineW        = 8;
  localparam int InDataW      = 72;
  localparam int InUserW      = 3;
  localparam int OutDataW     = 40;
  localparam int QueueDepth   = 2;

  localparam logic [2:0] OP_FILL   = 3'd0;
  localparam logic [2:0] OP_INVERT = 3'd1;
  localparam logic [2:0] OP_BLIT   = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    CMD_RMW,
    CMD_READ,
    CMD_CLEAR,
    CMD_ZERO
  } cmd_kind_e;

  // A line update is new = (old & keep) ^ flip over count lines from line.
  typedef struct packed {
    cmd_kind_e               kind;
    logic [LineW-1:0]        line;
    logic [LineW-1:0]        count;
    logic [MaxLineBits-1:0]  keep;
    logic [MaxLineBits-1:0]  flip;
  } cmd_t;

endpackage

/* rtl/core/mfbro_front.sv */
module mfbro_front #(
  parameter int LINE_COUNT = 128,
  parameter int PAGE_COUNT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        operation_i,
  input  logic [4:0]        x_offset_i,
  input  logic [6:0]        top_line_i,
  input  logic [5:0]        span_width_i,
  input  logic [7:0]        span_height_i,
  input  logic [6:0]        row_offset_i,
  input  logic              pixel_color_i,
  input  logic [31:0]       source_bits_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output mfbro_pkg::cmd_t   cmd_o
);
  import mfbro_pkg::*;

  localparam int LB = PAGE_COUNT * PageBits;
  localparam logic [MaxLineBits-1:0] LineMask =
    MaxLineBits'((33'(1) << LB) - 33'(1));

  logic [5:0]             w_sat;
  logic [MaxLineBits-1:0] ones, mask, shifted;
  logic [8:0]             top9, avail, height9, rect_cnt, blit_ln;
  logic                   blit_ok;
  cmd_t                   cmd_d, cmd_q;
  logic                   valid_q;

  always_comb begin
    w_sat    = (span_width_i > 6'(LB)) ? 6'(LB) : span_width_i;
    ones     = MaxLineBits'((33'(1) << w_sat) - 33'(1));
    mask     = (ones << x_offset_i) & LineMask;
    shifted  = source_bits_i << x_offset_i;
    top9     = {2'b00, top_line_i};
    avail    = (top9 < 9'(LINE_COUNT)) ? (9'(LINE_COUNT) - top9) : 9'd0;
    height9  = {1'b0, span_height_i};
    rect_cnt = (height9 < avail) ? height9 : avail;
    blit_ln  = top9 + {2'b00, row_offset_i};
    blit_ok  = ({1'b0, row_offset_i} < span_height_i) && (blit_ln < 9'(LINE_COUNT));

    cmd_d.kind  = CMD_ZERO;
    cmd_d.line  = top9[LineW-1:0];
    cmd_d.count = '0;
    cmd_d.keep  = ~mask;
    cmd_d.flip  = '0;
    unique case (operation_i) inside
      OP_FILL, OP_INVERT: begin
        if (rect_cnt != 9'd0) begin
          cmd_d.kind = CMD_RMW;
        end
        cmd_d.count = rect_cnt[LineW-1:0];
        if (operation_i == OP_INVERT) begin
          cmd_d.keep = '1;
          cmd_d.flip = mask;
        end else begin
          cmd_d.flip = pixel_color_i ? mask : '0;
        end
      end
      OP_BLIT: begin
        if (blit_ok) begin
          cmd_d.kind  = CMD_RMW;
          cmd_d.line  = blit_ln[LineW-1:0];
          cmd_d.count = LineW'(1);
          cmd_d.flip  = shifted & mask;
        end
      end
      OP_READ: begin
        if (top9 < 9'(LINE_COUNT)) begin
          cmd_d.kind = CMD_READ;
        end
      end
      OP_CLEAR: begin
        cmd_d.kind = CMD_CLEAR;
        cmd_d.flip = pixel_color_i ? LineMask : '0;
      end
      default: begin
        cmd_d.kind = CMD_ZERO;
      end
    endcase
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

/* rtl/core/mfbro_queue.sv */
module mfbro_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  mfbro_pkg::cmd_t push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output mfbro_pkg::cmd_t pop_cmd_o
);
  import mfbro_pkg::*;

  localparam int PW = $clog2(QueueDepth);

  cmd_t            slot_q [QueueDepth];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     fill_q;
  logic            push, pop;

  assign push_ready_o = fill_q != (PW+1)'(QueueDepth);
  assign pop_valid_o  = fill_q != '0;
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + (PW+1)'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/core/mfbro_back.sv */
`include "mono_framebuffer_raster_ops_assert.svh"

module mfbro_back #(
  parameter int LINE_COUNT = 128,
  parameter int PAGE_COUNT = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  mfbro_pkg::cmd_t cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     line_data_o,
  output logic [7:0]      lines_done_o
);
  import mfbro_pkg::*;

  localparam int LB = PAGE_COUNT * PageBits;
  localparam int AW = $clog2(LINE_COUNT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [LB-1:0]         mem_q [LINE_COUNT];
  logic [LINE_COUNT-1:0] vld_q;
  logic [LB-1:0]         fill_q, rdata_q, keep_q, flip_q, last_q, old_line, new_line;
  logic                  vld_rd_q;
  logic [1:0]            state_q, state_d;
  cmd_kind_e             kind_q;
  logic [LineW-1:0]      line_q, rem_q, done_q;
  logic [AW-1:0]         idx;
  logic                  cmd_pop, mem_we, out_load, out_valid_q;
  logic [31:0]           out_data_q;
  logic [7:0]            out_done_q;

  assign idx         = line_q[AW-1:0];
  assign cmd_ready_o = state_q == ST_IDLE;
  assign cmd_pop     = cmd_ready_o && cmd_valid_i;
  assign old_line    = vld_rd_q ? rdata_q : fill_q;
  assign new_line    = (old_line & keep_q) ^ flip_q;
  assign mem_we      = (state_q == ST_WR) && (kind_q == CMD_RMW);
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_RMW || cmd_i.kind == CMD_READ) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (kind_q != CMD_RMW || rem_q == LineW'(1)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_pop && cmd_i.kind == CMD_CLEAR) begin
        vld_q  <= '0;
        fill_q <= cmd_i.flip[LB-1:0];
      end else if (mem_we) begin
        vld_q[idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx] <= new_line;
    end
    if (state_q == ST_RD) begin
      rdata_q  <= mem_q[idx];
      vld_rd_q <= vld_q[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop) begin
      kind_q <= cmd_i.kind;
      line_q <= cmd_i.line;
      rem_q  <= cmd_i.count;
      keep_q <= cmd_i.keep[LB-1:0];
      flip_q <= cmd_i.flip[LB-1:0];
      last_q <= (cmd_i.kind == CMD_CLEAR) ? cmd_i.flip[LB-1:0] : '0;
      if (cmd_i.kind == CMD_RMW) begin
        done_q <= cmd_i.count;
      end else if (cmd_i.kind == CMD_CLEAR) begin
        done_q <= LineW'(LINE_COUNT);
      end else begin
        done_q <= '0;
      end
    end else if (state_q == ST_WR) begin
      last_q <= (kind_q == CMD_RMW) ? new_line : old_line;
      line_q <= line_q + LineW'(1);
      rem_q  <= rem_q - LineW'(1);
    end
    if (out_load) begin
      out_data_q <= 32'(last_q);
      out_done_q <= done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_data_o  = out_data_q;
  assign lines_done_o = out_done_q;

  `MFBRO_ASSERT(a_write_in_range, mem_we |-> (9'(line_q) < 9'(LINE_COUNT)), "write past last line")
  `MFBRO_ASSERT(a_write_has_work, (state_q == ST_WR && kind_q == CMD_RMW) |-> (rem_q != '0), "line update with no lines left")
  `MFBRO_ASSERT_NEXT(a_clear_drops_valid, cmd_pop && cmd_i.kind == CMD_CLEAR, vld_q == '0, "clear left valid lines")
  `MFBRO_ASSERT_NEXT(a_out_load, out_load, out_valid_q && state_q == ST_IDLE, "result not presented")

endmodule

/* rtl/core/mono_framebuffer_raster_ops.sv */
// Read or blit: front register, queue, then the back end's read, write and output states.
// A rectangle of n lines takes one read state and one write state per line in the back end.
// Clear drops every line's valid bit rather than rewriting the line memory.
// The back end owns the memory port and takes no new item until the last is done.
// Reset: asynchronous, active low; the buffer reads as all zeros afterwards.
module mono_framebuffer_raster_ops #(
  parameter int LINE_COUNT = mfbro_pkg::DefLineCount,
  parameter int PAGE_COUNT = mfbro_pkg::DefPageCount
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // x_offset[4:0], top_line[11:5], span_width[17:12], span_height[25:18],
  // row_offset[32:26], pixel_color[33], source_bits[65:34], zeros above.
  input  logic [mfbro_pkg::InDataW-1:0]   s_axis_tdata,
  // operation[2:0].
  input  logic [mfbro_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // line_data[31:0], lines_done[39:32].
  output logic [mfbro_pkg::OutDataW-1:0]  m_axis_tdata
);
  import mfbro_pkg::*;

  logic        front_valid, front_ready, back_valid, back_ready;
  cmd_t        front_cmd, back_cmd;
  logic [31:0] line_data;
  logic [7:0]  lines_done;

  mfbro_front #(
    .LINE_COUNT(LINE_COUNT),
    .PAGE_COUNT(PAGE_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .operation_i  (s_axis_tuser[2:0]),
    .x_offset_i   (s_axis_tdata[4:0]),
    .top_line_i   (s_axis_tdata[11:5]),
    .span_width_i (s_axis_tdata[17:12]),
    .span_height_i(s_axis_tdata[25:18]),
    .row_offset_i (s_axis_tdata[32:26]),
    .pixel_color_i(s_axis_tdata[33]),
    .source_bits_i(s_axis_tdata[65:34]),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (front_ready),
    .cmd_o        (front_cmd)
  );

  mfbro_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_cmd_i  (front_cmd),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready),
    .pop_cmd_o   (back_cmd)
  );

  mfbro_back #(
    .LINE_COUNT(LINE_COUNT),
    .PAGE_COUNT(PAGE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .line_data_o (line_data),
    .lines_done_o(lines_done)
  );

  assign m_axis_tdata = {lines_done, line_data};

endmodule
